### hdl/ids_pkg.sv
// Shared types and constants for the indexed deque store.
// Used by ids_ctrl, ids_cell and indexed_deque_store_core. No dependencies.
package ids_pkg;

    localparam int unsigned DEPTH_DEF  = 16;
    localparam int unsigned DATA_W_DEF = 32;

    // Fixed port widths
    localparam int unsigned OP_W   = 4;
    localparam int unsigned POS_W  = 8;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned OCC_W  = 5;
    // Compare width: holds a count of up to 256 and any position
    localparam int unsigned CMP_W  = 9;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND      = 4'd0,
        OP_REMOVE_TAIL = 4'd1,
        OP_READ_TAIL   = 4'd2,
        OP_INSERT      = 4'd3,
        OP_REMOVE_AT   = 4'd4,
        OP_READ_AT     = 4'd5,
        OP_REMOVE_HEAD = 4'd6,
        OP_READ_HEAD   = 4'd7,
        OP_CLEAR       = 4'd8
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BOUNDS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Shift command broadcast to the cell row
    typedef struct packed {
        logic             ins;  // open a gap at idx, write new word there
        logic             rem;  // close the gap at idx
        logic [POS_W-1:0] idx;  // target slot, also the read slot
    } shift_ctrl_t;

endpackage

### hdl/ids_cell.sv
// One storage slot of the deque row.
// Depends on ids_pkg (shift_ctrl_t, POS_W).
module ids_cell #(
    parameter int unsigned IDX    = 0,
    parameter int unsigned DATA_W = ids_pkg::DATA_W_DEF
) (
    input  logic                 aclk,
    input  ids_pkg::shift_ctrl_t ctrl,
    input  logic [DATA_W-1:0]    new_word,
    input  logic [DATA_W-1:0]    left_word,
    input  logic [DATA_W-1:0]    right_word,
    output logic [DATA_W-1:0]    word,
    output logic [DATA_W-1:0]    rd_word
);

    localparam logic [ids_pkg::POS_W-1:0] MY_IDX = ids_pkg::POS_W'(IDX);

    logic [DATA_W-1:0] word_reg;
    logic [DATA_W-1:0] word_next;

    always_comb begin
        word_next = word_reg;
        if (ctrl.ins) begin
            if (MY_IDX == ctrl.idx) begin
                word_next = new_word;
            end else if (MY_IDX > ctrl.idx) begin
                word_next = left_word;
            end
        end else if (ctrl.rem) begin
            if (MY_IDX >= ctrl.idx) begin
                word_next = right_word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    assign rd_word = (MY_IDX == ctrl.idx) ? word_reg : '0;

endmodule

### hdl/ids_ctrl.sv
// Operation decode: bounds, emptiness and fullness checks, shift command, next count.
// Depends on ids_pkg.
module ids_ctrl #(
    parameter int unsigned DEPTH = ids_pkg::DEPTH_DEF,
    parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                        fire,
    input  logic [ids_pkg::OP_W-1:0]    operation,
    input  logic [ids_pkg::POS_W-1:0]   position,
    input  logic [CNT_W-1:0]            count,
    output ids_pkg::shift_ctrl_t        ctrl,
    output ids_pkg::status_t            status,
    output logic                        has_word,
    output logic [CNT_W-1:0]            count_next
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [ids_pkg::CMP_W-1:0] pos_c;
    logic [ids_pkg::CMP_W-1:0] cnt_c;
    logic [ids_pkg::POS_W-1:0] tail_idx;
    logic                      is_empty;
    logic                      is_full;
    logic                      ins;
    logic                      rem;

    assign pos_c    = ids_pkg::CMP_W'(position);
    assign cnt_c    = ids_pkg::CMP_W'(count);
    assign tail_idx = ids_pkg::POS_W'(count - CNT_W'(1));
    assign is_empty = (count == '0);
    assign is_full  = (count == FULL_CNT);

    always_comb begin
        ins      = 1'b0;
        rem      = 1'b0;
        has_word = 1'b0;
        status   = ids_pkg::ST_OK;
        ctrl.idx = '0;
        case (ids_pkg::op_t'(operation))
            ids_pkg::OP_APPEND: begin
                ctrl.idx = ids_pkg::POS_W'(count);
                if (is_full) status = ids_pkg::ST_FULL;
                else         ins    = 1'b1;
            end
            ids_pkg::OP_REMOVE_TAIL, ids_pkg::OP_READ_TAIL: begin
                ctrl.idx = tail_idx;
                if (is_empty) begin
                    status = ids_pkg::ST_EMPTY;
                end else begin
                    has_word = 1'b1;
                    rem      = (operation == ids_pkg::OP_REMOVE_TAIL);
                end
            end
            ids_pkg::OP_INSERT: begin
                ctrl.idx = position;
                if (pos_c > cnt_c)  status = ids_pkg::ST_BOUNDS;
                else if (is_full)   status = ids_pkg::ST_FULL;
                else                ins    = 1'b1;
            end
            ids_pkg::OP_REMOVE_AT, ids_pkg::OP_READ_AT: begin
                ctrl.idx = position;
                if (pos_c >= cnt_c) begin
                    status = ids_pkg::ST_BOUNDS;
                end else begin
                    has_word = 1'b1;
                    rem      = (operation == ids_pkg::OP_REMOVE_AT);
                end
            end
            ids_pkg::OP_REMOVE_HEAD, ids_pkg::OP_READ_HEAD: begin
                if (is_empty) begin
                    status = ids_pkg::ST_EMPTY;
                end else begin
                    has_word = 1'b1;
                    rem      = (operation == ids_pkg::OP_REMOVE_HEAD);
                end
            end
            default: ;
        endcase
        ctrl.ins = ins & fire;
        ctrl.rem = rem & fire;
    end

    always_comb begin
        if (operation == ids_pkg::OP_CLEAR) begin
            count_next = '0;
        end else if (ins) begin
            count_next = count + CNT_W'(1);
        end else if (rem) begin
            count_next = count - CNT_W'(1);
        end else begin
            count_next = count;
        end
    end

endmodule

### hdl/indexed_deque_store_core.sv
// Indexed deque store: an ordered row of DEPTH words, position 0 the head.
// Every request (append, insert, remove or read at head, tail or an index,
// clear) is served in place: the row of slot cells shifts up or down
// around the target index at the edge that accepts it, and the response is held in an
// output register, so a new request is taken each cycle while m_ready is
// high. Errors are reported in m_status; m_occupancy is the count after
// the request, low 5 bits. Depends on ids_pkg, ids_ctrl and ids_cell.
module indexed_deque_store_core #(
    parameter int unsigned DEPTH  = ids_pkg::DEPTH_DEF,
    parameter int unsigned DATA_W = ids_pkg::DATA_W_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ids_pkg::OP_W-1:0]    s_operation,
    input  logic [ids_pkg::POS_W-1:0]   s_position,
    input  logic [ids_pkg::WORD_W-1:0]  s_word_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ids_pkg::WORD_W-1:0]  m_word_out,
    output logic [ids_pkg::STAT_W-1:0]  m_status,
    output logic [ids_pkg::OCC_W-1:0]   m_occupancy
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic                        take;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    ids_pkg::shift_ctrl_t        ctrl;
    ids_pkg::status_t            status;
    logic                        has_word;
    logic [DATA_W-1:0]           new_word;
    logic [DATA_W-1:0]           cell_word [DEPTH];
    logic [DATA_W-1:0]           cell_rd   [DEPTH];
    logic [DATA_W-1:0]           rd_word;

    logic                        m_valid_reg;
    logic [ids_pkg::WORD_W-1:0]  m_word_out_reg;
    logic [ids_pkg::STAT_W-1:0]  m_status_reg;
    logic [ids_pkg::OCC_W-1:0]   m_occupancy_reg;

    assign s_ready  = !m_valid_reg || m_ready;
    assign take     = s_valid && s_ready;
    assign new_word = DATA_W'(s_word_in);

    ids_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .fire       (take),
        .operation  (s_operation),
        .position   (s_position),
        .count      (count_reg),
        .ctrl       (ctrl),
        .status     (status),
        .has_word   (has_word),
        .count_next (count_next)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_slot
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;
        if (i == 0) begin : g_head
            assign left_w = new_word;
        end else begin : g_mid_l
            assign left_w = cell_word[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign right_w = cell_word[i];
        end else begin : g_mid_r
            assign right_w = cell_word[i+1];
        end
        ids_cell #(
            .IDX    (i),
            .DATA_W (DATA_W)
        ) u_slot (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .new_word   (new_word),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[i]),
            .rd_word    (cell_rd[i])
        );
    end

    // Only the addressed slot drives a nonzero read word
    always_comb begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_word = rd_word | cell_rd[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_word_out_reg  <= has_word ? ids_pkg::WORD_W'(rd_word) : '0;
            m_status_reg    <= status;
            m_occupancy_reg <= ids_pkg::OCC_W'(count_next);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_word_out  = m_word_out_reg;
    assign m_status    = m_status_reg;
    assign m_occupancy = m_occupancy_reg;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_deque_store_core: directed and random requests
// against an in-bench deque predictor, with random idling and backpressure.
// Depends on ids_pkg and the indexed_deque_store_core RTL.
module testbench;

    localparam int DEPTH       = ids_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 200;
    localparam logic [ids_pkg::OP_W-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [ids_pkg::OP_W-1:0] OP_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [ids_pkg::WORD_W-1:0] word;
        ids_pkg::status_t           status;
        logic [ids_pkg::OCC_W-1:0]  occ;
    } deque_result_t;

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic [ids_pkg::OP_W-1:0]   s_operation = '0;
    logic [ids_pkg::POS_W-1:0]  s_position  = '0;
    logic [ids_pkg::WORD_W-1:0] s_word_in   = '0;
    logic                       m_valid;
    logic                       m_ready     = 1'b0;
    logic [ids_pkg::WORD_W-1:0] m_word_out;
    logic [ids_pkg::STAT_W-1:0] m_status;
    logic [ids_pkg::OCC_W-1:0]  m_occupancy;

    // predictor state
    logic [ids_pkg::WORD_W-1:0] slot_words [DEPTH];
    int                         fill_cnt = 0;
    deque_result_t              pending_results [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int hold_cycles    = 0;
    bit sender_idle    = 1'b1;
    bit receiver_idle  = 1'b1;

    indexed_deque_store_core #(
        .DEPTH(DEPTH),
        .DATA_W(ids_pkg::DATA_W_DEF)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operation(s_operation),
        .s_position(s_position),
        .s_word_in(s_word_in),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_word_out(m_word_out),
        .m_status(m_status),
        .m_occupancy(m_occupancy)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("indexed_deque_store_core regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [ids_pkg::WORD_W-1:0] got,
                                   logic [ids_pkg::WORD_W-1:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] mismatch %s: got 0x%h expected 0x%h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic deque_result_t predict_deque_op(logic [ids_pkg::OP_W-1:0] op,
                                                       logic [ids_pkg::POS_W-1:0] pos,
                                                       logic [ids_pkg::WORD_W-1:0] word);
        deque_result_t r;
        int i;
        int idx;
        r.word   = '0;
        r.status = ids_pkg::ST_OK;
        idx      = int'(pos);
        case (op)
            ids_pkg::OP_APPEND: begin
                if (fill_cnt >= DEPTH) begin
                    r.status = ids_pkg::ST_FULL;
                end else begin
                    slot_words[fill_cnt] = word;
                    fill_cnt++;
                end
            end
            ids_pkg::OP_REMOVE_TAIL, ids_pkg::OP_READ_TAIL: begin
                if (fill_cnt == 0) begin
                    r.status = ids_pkg::ST_EMPTY;
                end else begin
                    r.word = slot_words[fill_cnt-1];
                    if (op == ids_pkg::OP_REMOVE_TAIL) fill_cnt--;
                end
            end
            ids_pkg::OP_INSERT: begin
                // bounds is checked ahead of fullness
                if (idx > fill_cnt) begin
                    r.status = ids_pkg::ST_BOUNDS;
                end else if (fill_cnt >= DEPTH) begin
                    r.status = ids_pkg::ST_FULL;
                end else begin
                    for (i = fill_cnt; i > idx; i--) slot_words[i] = slot_words[i-1];
                    slot_words[idx] = word;
                    fill_cnt++;
                end
            end
            ids_pkg::OP_REMOVE_AT, ids_pkg::OP_READ_AT,
            ids_pkg::OP_REMOVE_HEAD, ids_pkg::OP_READ_HEAD: begin
                if (op == ids_pkg::OP_REMOVE_HEAD || op == ids_pkg::OP_READ_HEAD) begin
                    idx = 0;
                    if (fill_cnt == 0) r.status = ids_pkg::ST_EMPTY;
                end else if (idx >= fill_cnt) begin
                    r.status = ids_pkg::ST_BOUNDS;
                end
                if (r.status == ids_pkg::ST_OK) begin
                    r.word = slot_words[idx];
                    if (op == ids_pkg::OP_REMOVE_AT || op == ids_pkg::OP_REMOVE_HEAD) begin
                        for (i = idx; i < fill_cnt - 1; i++) slot_words[i] = slot_words[i+1];
                        fill_cnt--;
                    end
                end
            end
            ids_pkg::OP_CLEAR: fill_cnt = 0;
            default: ;
        endcase
        r.occ = ids_pkg::OCC_W'(fill_cnt);
        return r;
    endfunction

    // Called at a rising edge; returns at the edge that accepted the request.
    task automatic send_request(logic [ids_pkg::OP_W-1:0] op, logic [ids_pkg::POS_W-1:0] pos,
                                logic [ids_pkg::WORD_W-1:0] word);
        if (sender_idle && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_position  <= pos;
        s_word_in   <= word;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_deque_op(op, pos, word));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // receiver: random stall bursts, plus an occasional long hold-off
    initial begin : result_ready_driver
        int n;
        int k;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                n = hold_cycles;
                hold_cycles = 0;
                m_ready <= 1'b0;
                for (k = 0; k < n; k++) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (receiver_idle && $urandom_range(0, 6) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_monitor
        deque_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", m_word_out, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_word_out !== want.word)
                    report_mismatch("word_out", m_word_out, want.word);
                if (m_status !== want.status)
                    report_mismatch("status", ids_pkg::WORD_W'(m_status),
                                    ids_pkg::WORD_W'(want.status));
                if (m_occupancy !== want.occ)
                    report_mismatch("occupancy", ids_pkg::WORD_W'(m_occupancy),
                                    ids_pkg::WORD_W'(want.occ));
            end
        end
    end

    task automatic test_empty_store();
        send_request(ids_pkg::OP_READ_HEAD, 8'd0, 32'h0);
        send_request(ids_pkg::OP_REMOVE_HEAD, 8'd0, 32'h0);
        send_request(ids_pkg::OP_READ_TAIL, 8'd0, 32'h0);
        send_request(ids_pkg::OP_REMOVE_TAIL, 8'd0, 32'h0);
        send_request(ids_pkg::OP_READ_AT, 8'd0, 32'h0);      // every index is past the count
        send_request(ids_pkg::OP_REMOVE_AT, 8'hFF, 32'h0);
        send_request(ids_pkg::OP_INSERT, 8'd1, 32'hDEAD_BEEF);
    endtask

    task automatic test_basic_ops();
        send_request(ids_pkg::OP_INSERT, 8'd0, 32'hFFFF_FFFF); // index equal to count appends
        send_request(ids_pkg::OP_APPEND, 8'hFF, 32'h0000_0000);
        send_request(ids_pkg::OP_APPEND, 8'd0, 32'hA5A5_5A5A);
        send_request(ids_pkg::OP_READ_TAIL, 8'd0, 32'h0);
        send_request(ids_pkg::OP_READ_AT, 8'd1, 32'h0);
        send_request(ids_pkg::OP_INSERT, 8'd1, 32'h1234_5678);
        send_request(ids_pkg::OP_INSERT, 8'd5, 32'h0);          // one past the count
        send_request(ids_pkg::OP_READ_AT, 8'd4, 32'h0);
        send_request(ids_pkg::OP_REMOVE_AT, 8'd2, 32'h0);
        send_request(ids_pkg::OP_REMOVE_HEAD, 8'd0, 32'h0);
        send_request(ids_pkg::OP_READ_HEAD, 8'd0, 32'h0);
        send_request(OP_UNUSED_LO, 8'd0, 32'hFFFF_FFFF);
        send_request(OP_UNUSED_HI, 8'hFF, 32'hFFFF_FFFF);
        send_request(ids_pkg::OP_REMOVE_TAIL, 8'd0, 32'h0);
        send_request(ids_pkg::OP_CLEAR, 8'd0, 32'h0);
        send_request(ids_pkg::OP_READ_TAIL, 8'd0, 32'h0);
    endtask

    task automatic test_full_store();
        while (fill_cnt < DEPTH) send_request(ids_pkg::OP_APPEND, 8'd0, $urandom);
        send_request(ids_pkg::OP_APPEND, 8'd0, 32'h5555_AAAA);
        send_request(ids_pkg::OP_INSERT, 8'(DEPTH), 32'h5555_AAAA);
        send_request(ids_pkg::OP_INSERT, 8'(DEPTH + 1), 32'h5555_AAAA); // bounds wins over full
        send_request(ids_pkg::OP_INSERT, 8'd0, 32'h5555_AAAA);
        send_request(ids_pkg::OP_READ_AT, 8'(DEPTH - 1), 32'h0);
        send_request(ids_pkg::OP_REMOVE_AT, 8'(DEPTH - 1), 32'h0);
        send_request(ids_pkg::OP_INSERT, 8'd0, 32'hCAFE_F00D);
        send_request(ids_pkg::OP_READ_HEAD, 8'd0, 32'h0);
        send_request(ids_pkg::OP_CLEAR, 8'd0, 32'h0);
    endtask

    task automatic run_random_mix(int count, bit grow);
        int k;
        int pick;
        logic [ids_pkg::OP_W-1:0]  op;
        logic [ids_pkg::POS_W-1:0] pos;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 199);
            if (pick == 0) begin
                op = ids_pkg::OP_CLEAR;
            end else if (pick < (grow ? 110 : 60)) begin
                op = $urandom_range(0, 1) ? ids_pkg::OP_APPEND : ids_pkg::OP_INSERT;
            end else if (pick < 190) begin
                case ($urandom_range(0, 5))
                    0: op = ids_pkg::OP_REMOVE_TAIL;
                    1: op = ids_pkg::OP_READ_TAIL;
                    2: op = ids_pkg::OP_REMOVE_AT;
                    3: op = ids_pkg::OP_READ_AT;
                    4: op = ids_pkg::OP_REMOVE_HEAD;
                    default: op = ids_pkg::OP_READ_HEAD;
                endcase
            end else begin
                op = ids_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            end
            // mostly legal indices, some anywhere in the field
            if ($urandom_range(0, 9) == 0)
                pos = ids_pkg::POS_W'($urandom_range(0, 255));
            else if (op == ids_pkg::OP_INSERT)
                pos = ids_pkg::POS_W'($urandom_range(0, fill_cnt));
            else
                pos = (fill_cnt > 0) ? ids_pkg::POS_W'($urandom_range(0, fill_cnt - 1)) : '0;
            send_request(op, pos, $urandom);
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 80;
        run_random_mix(30, 1'b1);
    endtask

    task automatic test_drain_pause();
        run_random_mix(10, 1'b1);
        wait_drained();
        run_random_mix(10, 1'b0);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_store();
        test_basic_ops();
        test_full_store();
        test_backpressure();
        test_drain_pause();
        run_random_mix(125, 1'b1);
        run_random_mix(125, 1'b0);
        run_random_mix(125, 1'b1);
        run_random_mix(125, 1'b0);
        // last stretch at full rate on both sides
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        run_random_mix(100, 1'b1);
        wait_drained();
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("results still pending",
                            ids_pkg::WORD_W'(pending_results.size()), '0);
        if (mismatch_count == 0)
            $display("indexed_deque_store_core regression: pass");
        else
            $display("indexed_deque_store_core regression: fail");
        $finish;
    end

endmodule
